// ----- sv/mcbd_pkg.sv -----
package mcbd_pkg;

    localparam int CHANNELS_DEFAULT = 32;
    localparam int CHANNEL_W        = 6;
    localparam int TIME_W           = 32;
    localparam int DEBOUNCE_W       = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

    // raw pin levels, active-low buttons
    localparam logic LEVEL_RELEASED = 1'b1;
    localparam logic LEVEL_PRESSED  = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0]    now_ms;
        logic                 level;
        logic [CHANNEL_W-1:0] channel;
    } mcbd_sample_t;

endpackage

// ----- sv/mcbd_state.sv -----
module mcbd_state
    import mcbd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  update,
    input  mcbd_sample_t          sample,
    input  logic [DEBOUNCE_W-1:0] debounce_ms,
    output logic                  pressed
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CHANNELS-1:0] last_raw_reg;
    logic [CHANNELS-1:0] stable_reg;
    logic [TIME_W-1:0]   change_time_reg [CHANNELS];

    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              raw_changed;
    logic [TIME_W-1:0] elapsed;
    logic              accept;

    assign idx         = sample.channel[IDX_W-1:0];
    assign in_range    = ({1'b0, sample.channel} < (CHANNEL_W + 1)'(CHANNELS));
    assign raw_changed = (sample.level != last_raw_reg[idx]);
    assign elapsed     = sample.now_ms - change_time_reg[idx];

    // a raw change restarts the timer, so a sample that changes the raw level is never accepted
    assign accept = !raw_changed
                 && (elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms})
                 && (sample.level != stable_reg[idx]);

    assign pressed = in_range && accept && (sample.level == LEVEL_PRESSED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= '1;
            stable_reg   <= '1;
            for (int i = 0; i < CHANNELS; i++)
            begin
                change_time_reg[i] <= '0;
            end
        end
        else if (update && in_range)
        begin
            last_raw_reg[idx] <= sample.level;
            if (raw_changed)
            begin
                change_time_reg[idx] <= sample.now_ms;
            end
            if (accept)
            begin
                stable_reg[idx] <= sample.level;
            end
        end
    end

endmodule

// ----- sv/multi_channel_button_debounce.sv -----
// path: an input transfer passes the input register, then the result register, to the master side
// throughput: one sample per cycle while the master side does not stall; the channel state is
//   read and written as the sample moves from the input register into the result register
// reset: all channels released (raw and stable high), change times zero,
//   debounce interval 50 ms, both pipeline registers empty
module multi_channel_button_debounce
    import mcbd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: debounce interval in ms
    input  logic                  cfg_we,
    input  logic [DEBOUNCE_W-1:0] cfg_wdata,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // channel[5:0], level[6], now_ms[38:7], zero[39]
    // press stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // pressed[0], zero[7:1]
);

    logic [DEBOUNCE_W-1:0] debounce_reg;

    // input register
    logic         in_valid_reg;
    mcbd_sample_t in_sample_reg;

    // result register
    logic         out_valid_reg;
    logic         out_pressed_reg;

    logic         advance;
    logic         pressed;

    // the result register frees up in the same cycle it is taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_pressed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload capture on every input transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg.channel <= s_tdata[CHANNEL_W-1:0];
            in_sample_reg.level   <= s_tdata[CHANNEL_W];
            in_sample_reg.now_ms  <= s_tdata[CHANNEL_W+TIME_W:CHANNEL_W+1];
        end
    end

    // per-channel state bank, updated as the sample moves into the result register
    mcbd_state #(
        .CHANNELS (CHANNELS)
    ) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (advance),
        .sample      (in_sample_reg),
        .debounce_ms (debounce_reg),
        .pressed     (pressed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pressed_reg <= pressed;
        end
    end

    // a held sample moves on whenever the result register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held sample did not advance into empty result register");

    // an empty pipeline always takes a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid_reg && !out_valid_reg) |-> s_tready)
        else $error("empty pipeline refused a transfer");

    // a stalled result blocks the input only while the input register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready) |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule
